// ----- hw/rtl/itp_pkg.sv -----
// Shared types, codes and constants of the inverse table interpolator.
package itp_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int SAMPLE_W    = 32;
    localparam int ENTRY_IDX_W = 8;
    localparam int USED_W      = 9;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int MAPPED_W    = 48;
    localparam int FRAC_W      = 16;
    localparam int DIV_STEPS   = FRAC_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [USED_W-1:0]       ENTRIES_RESET = 9'd256;
    localparam logic [SAMPLE_W-1:0]     STEP_RESET    = 32'h0001_0000;
    localparam logic signed [CFG_W-1:0] FIRST_RESET   = 32'sd0;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_itp_op;

    typedef enum logic [2:0] {
        ST_INTERP    = 3'd0,
        ST_EXACT     = 3'd1,
        ST_BELOW     = 3'd2,
        ST_ABOVE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_itp_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_USED = 2'd0,
        CFG_STEP_VALUE   = 2'd1,
        CFG_FIRST_VALUE  = 2'd2
    } t_itp_cfg_idx;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_MID,
        POS_LAST,
        POS_INTERP
    } t_itp_pos;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_CMP,
        S_NB,
        S_DIV,
        S_POS,
        S_MUL,
        S_OUT
    } t_itp_state;

    typedef struct packed {
        t_itp_op                opcode;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [SAMPLE_W-1:0]    sample_value;
    } t_itp_in;

    typedef struct packed {
        logic signed [MAPPED_W-1:0] mapped_value;
        t_itp_status                lookup_status;
    } t_itp_out;

    typedef struct packed {
        logic        wr;
        logic        start;
        logic        rd_mid;
        logic        rd_nb;
        logic        step;
        logic        div_start;
        logic        div_step;
        logic        pos_load;
        t_itp_pos    pos_kind;
        logic        mul;
        logic        out_load;
        logic        out_zero;
        t_itp_status out_status;
    } t_itp_cmd;

    typedef struct packed {
        logic range_empty;
        logic tm_lt_q;
        logic tm_gt_q;
        logic mid_last;
        logic mid_zero;
        logic nb_brackets;
        logic div_last;
    } t_itp_stat;

endpackage

// ----- hw/rtl/inverse_table_interpolator.sv -----
// Top level of the inverse table interpolator: sequencer plus datapath.
//
// Write beats (opcode write) load one table entry; the block is ready again
// on the next cycle and produces no result. A write to an entry at or beyond
// TABLE_DEPTH is dropped. Query beats run a binary search over the first
// min(entries_used, TABLE_DEPTH) entries through the single read port of the
// table memory: each probe reads the midpoint, compares it, then reads and
// compares the neighbour, and a search takes up to about log2(n) + 1 probes.
// An interpolated result then passes the restoring divider (one fraction bit
// per cycle), forms the Q.16 position, goes through the 32x24 multiplier and
// finally adds first_value, saturates and loads the output register; exact,
// end-of-table or not-found answers skip the divider. Only one query is in
// flight; input ready is high while the sequencer is idle, and a finished
// result may wait in the output register while the next beat is taken. Table
// entries are not cleared at reset; a query must only reach entries that have
// been written. Configuration writes are taken at any cycle but must only be
// issued while the block is idle.
module inverse_table_interpolator #(
    parameter int TABLE_DEPTH = itp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [itp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  itp_pkg::t_itp_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output itp_pkg::t_itp_out             o_out
);

    itp_pkg::t_itp_cmd  cmd;
    itp_pkg::t_itp_stat stat;

    // sequencer: one state per step of the search, divide and scale
    itp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: table memory, configuration registers and arithmetic
    itp_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule

// ----- hw/rtl/itp_ctrl.sv -----
// Sequencer of the inverse table interpolator: search, divide, scale and output control.
module itp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  itp_pkg::t_itp_op   i_opcode,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  itp_pkg::t_itp_stat i_stat,
    output itp_pkg::t_itp_cmd  o_cmd
);

    itp_pkg::t_itp_state  r_state, n_state;
    itp_pkg::t_itp_status r_status, n_status;
    logic                 r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itp_pkg::S_IDLE;
            r_status    <= itp_pkg::ST_NOT_FOUND;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.pos_kind   = itp_pkg::POS_ZERO;
        o_cmd.out_status = r_status;
        unique case (r_state)
            itp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == itp_pkg::OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = itp_pkg::S_MID;
                    end
                end
            end
            itp_pkg::S_MID: begin
                if (i_stat.range_empty) begin
                    n_status = itp_pkg::ST_NOT_FOUND;
                    n_state  = itp_pkg::S_OUT;
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = itp_pkg::S_CMP;
                end
            end
            itp_pkg::S_CMP: begin
                if (i_stat.tm_lt_q) begin
                    if (i_stat.mid_last) begin
                        o_cmd.pos_load = 1'b1;
                        o_cmd.pos_kind = itp_pkg::POS_LAST;
                        n_status       = itp_pkg::ST_ABOVE;
                        n_state        = itp_pkg::S_MUL;
                    end else begin
                        o_cmd.rd_nb = 1'b1;
                        n_state     = itp_pkg::S_NB;
                    end
                end else if (i_stat.tm_gt_q) begin
                    if (i_stat.mid_zero) begin
                        o_cmd.pos_load = 1'b1;
                        o_cmd.pos_kind = itp_pkg::POS_ZERO;
                        n_status       = itp_pkg::ST_BELOW;
                        n_state        = itp_pkg::S_MUL;
                    end else begin
                        o_cmd.rd_nb = 1'b1;
                        n_state     = itp_pkg::S_NB;
                    end
                end else begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.pos_kind = itp_pkg::POS_MID;
                    n_status       = itp_pkg::ST_EXACT;
                    n_state        = itp_pkg::S_MUL;
                end
            end
            itp_pkg::S_NB: begin
                if (i_stat.nb_brackets) begin
                    o_cmd.div_start = 1'b1;
                    n_status        = itp_pkg::ST_INTERP;
                    n_state         = itp_pkg::S_DIV;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = itp_pkg::S_MID;
                end
            end
            itp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = itp_pkg::S_POS;
                end
            end
            itp_pkg::S_POS: begin
                o_cmd.pos_load = 1'b1;
                o_cmd.pos_kind = itp_pkg::POS_INTERP;
                n_state        = itp_pkg::S_MUL;
            end
            itp_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = itp_pkg::S_OUT;
            end
            itp_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = (r_status == itp_pkg::ST_NOT_FOUND);
                    n_out_valid    = 1'b1;
                    n_state        = itp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/itp_dpath.sv -----
// Datapath of the inverse table interpolator: table memory, search bounds, divider, scaler.
module itp_dpath #(
    parameter int TABLE_DEPTH = itp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [itp_pkg::CFG_W-1:0]       i_cfg_data,
    input  itp_pkg::t_itp_in                i_in,
    input  itp_pkg::t_itp_cmd               i_cmd,
    output itp_pkg::t_itp_stat              o_stat,
    output itp_pkg::t_itp_out               o_out
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W   = IDX_W + itp_pkg::FRAC_W;
    localparam int PROD_W  = itp_pkg::SAMPLE_W + POS_W;
    localparam int SUM_W   = itp_pkg::MAPPED_W + 2;
    localparam int SW      = itp_pkg::SAMPLE_W;
    localparam int FW      = itp_pkg::FRAC_W;
    localparam int MW      = itp_pkg::MAPPED_W;
    localparam logic [31:0] DEPTH32 = TABLE_DEPTH;

    // configuration
    logic [itp_pkg::USED_W-1:0]      r_used;
    logic [SW-1:0]                   r_step;
    logic signed [itp_pkg::CFG_W-1:0] r_first;

    logic [SW-1:0]    r_mem [TABLE_DEPTH];
    logic [SW-1:0]    r_rdata;
    logic [SW-1:0]    r_q;
    logic [SW-1:0]    r_tm;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] r_lo, r_hi, r_mid, r_lo_idx;
    logic             r_up;
    logic [SW-1:0]    r_rem, r_span;
    logic [FW-1:0]    r_quot;
    logic [itp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [POS_W-1:0] r_pos;
    logic [PROD_W-1:0] r_prod;
    itp_pkg::t_itp_out r_out;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid_calc;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] mid_plus1;
    logic             wr_ok;
    logic [SW-1:0]    div_a, div_b;
    logic [SW:0]      rem_shift;
    logic             rem_ge;
    logic [PROD_W-FW-1:0]     prod_hi;
    logic signed [SUM_W-1:0]  sum;
    logic                     sum_fits;
    logic signed [MW-1:0]     sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= itp_pkg::ENTRIES_RESET;
            r_step  <= itp_pkg::STEP_RESET;
            r_first <= itp_pkg::FIRST_RESET;
        end else if (i_cfg_we) begin
            unique case (itp_pkg::t_itp_cfg_idx'(i_cfg_idx))
                itp_pkg::CFG_ENTRIES_USED: r_used  <= i_cfg_data[itp_pkg::USED_W-1:0];
                itp_pkg::CFG_STEP_VALUE:   r_step  <= i_cfg_data;
                itp_pkg::CFG_FIRST_VALUE:  r_first <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign n_eff = (32'(r_used) > DEPTH32) ? CNT_W'(DEPTH32) : CNT_W'(r_used);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_calc  = mid_sum[IDX_W:1];
    assign mid_plus1 = CNT_W'(r_mid) + CNT_W'(1);
    assign rd_addr   = i_cmd.rd_nb ? (o_stat.tm_lt_q ? r_mid + IDX_W'(1) : r_mid - IDX_W'(1))
                                   : mid_calc;
    assign wr_ok     = 32'(i_in.entry_index) < DEPTH32;

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            r_mem[IDX_W'(i_in.entry_index)] <= i_in.sample_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_stat.range_empty = (r_n == '0) || (r_lo > r_hi);
    assign o_stat.tm_lt_q     = r_rdata < r_q;
    assign o_stat.tm_gt_q     = r_rdata > r_q;
    assign o_stat.mid_last    = mid_plus1 >= r_n;
    assign o_stat.mid_zero    = (r_mid == '0);
    assign o_stat.nb_brackets = r_up ? (r_rdata > r_q) : (r_rdata < r_q);
    assign o_stat.div_last    = (r_div_cnt == itp_pkg::DIV_CNT_W'(itp_pkg::DIV_STEPS - 1));

    assign div_a     = r_up ? r_tm : r_rdata;
    assign div_b     = r_up ? r_rdata : r_tm;
    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, r_span};

    assign prod_hi  = r_prod[PROD_W-1:FW];
    assign sum      = $signed(SUM_W'(prod_hi)) + SUM_W'(r_first);
    assign sum_fits = (&sum[SUM_W-1:MW-1]) || ~(|sum[SUM_W-1:MW-1]);
    assign sat      = sum_fits ? sum[MW-1:0]
                    : (sum[SUM_W-1] ? {1'b1, {(MW-1){1'b0}}} : {1'b0, {(MW-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q  <= i_in.sample_value;
            r_n  <= n_eff;
            r_lo <= '0;
            r_hi <= IDX_W'(n_eff - CNT_W'(1));
        end
        if (i_cmd.rd_mid) begin
            r_mid <= mid_calc;
        end
        if (i_cmd.rd_nb) begin
            r_tm <= r_rdata;
            r_up <= o_stat.tm_lt_q;
        end
        if (i_cmd.step) begin
            if (r_up) begin
                r_lo <= r_mid + IDX_W'(1);
            end else begin
                r_hi <= r_mid - IDX_W'(1);
            end
        end
        // restoring divider, one quotient bit per cycle
        if (i_cmd.div_start) begin
            r_rem     <= r_q - div_a;
            r_span    <= div_b - div_a;
            r_lo_idx  <= r_up ? r_mid : r_mid - IDX_W'(1);
            r_quot    <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? SW'(rem_shift - {1'b0, r_span}) : rem_shift[SW-1:0];
            r_quot    <= {r_quot[FW-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + itp_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.pos_load) begin
            unique case (i_cmd.pos_kind)
                itp_pkg::POS_ZERO:   r_pos <= '0;
                itp_pkg::POS_MID:    r_pos <= {r_mid, {FW{1'b0}}};
                itp_pkg::POS_LAST:   r_pos <= {IDX_W'(r_n - CNT_W'(1)), {FW{1'b0}}};
                itp_pkg::POS_INTERP: r_pos <= {r_lo_idx, r_quot};
                default:             r_pos <= '0;
            endcase
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_step) * PROD_W'(r_pos);
        end
        if (i_cmd.out_load) begin
            r_out.mapped_value  <= i_cmd.out_zero ? '0 : sat;
            r_out.lookup_status <= i_cmd.out_status;
        end
    end

    assign o_out = r_out;

endmodule

// ----- hw/rtl/itp_checker.sv -----
// Port-level checks of the inverse table interpolator, bound to the top level.
module itp_port_checks (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input itp_pkg::t_itp_in  i_in,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input itp_pkg::t_itp_out o_out
);

    // a query occupies the block for at least the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.opcode == itp_pkg::OP_QUERY) |=> !o_in_ready)
        else $error("ready stayed high after a query beat");

    // a table write leaves the block ready for the next beat
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.opcode == itp_pkg::OP_WRITE) |=> o_in_ready)
        else $error("ready dropped after a write beat");

    // a new result appears only at the end of a query, never from idle
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the block was idle");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result beat changed or vanished");

endmodule

bind inverse_table_interpolator itp_port_checks u_itp_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ----- bench/itp_checker.sv -----
// Checker for the inverse table interpolator: predicts each lookup and compares results.
module itp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [itp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  itp_pkg::t_itp_in              i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  itp_pkg::t_itp_out             i_out,
    output int                            o_pending,
    output int                            o_fail_count
);
    import itp_pkg::*;

    localparam int     DEPTH      = TABLE_DEPTH_DEF;
    localparam int     SHOWN_MAX  = 10;
    localparam longint MAPPED_MAX = (longint'(1) <<< (MAPPED_W - 1)) - 1;
    localparam longint MAPPED_MIN = -(longint'(1) <<< (MAPPED_W - 1));

    logic [SAMPLE_W-1:0]     samples [DEPTH];
    logic [USED_W-1:0]       used_cnt;
    logic [SAMPLE_W-1:0]     step_val;
    logic signed [CFG_W-1:0] first_val;
    t_itp_out                lookups_due [$];
    int                      mismatches = 0;

    // Mapped value at a Q.16 table position, clamped to the output range
    function automatic logic signed [MAPPED_W-1:0] value_at(logic [63:0] pos);
        logic [63:0] prod;
        longint      sum;
        prod = {32'd0, step_val} * pos;
        sum  = longint'(prod >> FRAC_W) + longint'(first_val);
        if (sum > MAPPED_MAX) sum = MAPPED_MAX;
        if (sum < MAPPED_MIN) sum = MAPPED_MIN;
        return sum[MAPPED_W-1:0];
    endfunction

    // Q.16 position of q between entry lo_idx (value a) and the next one (value b)
    function automatic logic [63:0] position_between(int lo_idx, logic [31:0] a,
                                                     logic [31:0] b, logic [31:0] q);
        logic [63:0] frac;
        frac = '0;
        if (b != a)
            frac = ({32'd0, q - a} << FRAC_W) / {32'd0, b - a};
        return (64'(lo_idx) << FRAC_W) | {48'd0, frac[FRAC_W-1:0]};
    endfunction

    function automatic t_itp_out lookup(logic [SAMPLE_W-1:0] q);
        t_itp_out res;
        int       n;
        int       lo;
        int       hi;
        int       mid;
        res.mapped_value  = '0;
        res.lookup_status = ST_NOT_FOUND;
        n  = (int'(used_cnt) > DEPTH) ? DEPTH : int'(used_cnt);
        lo = 0;
        hi = n - 1;
        while (hi >= lo) begin
            mid = (lo + hi) / 2;
            if (samples[mid] < q) begin
                if (mid + 1 >= n) begin
                    res.mapped_value  = value_at(64'(n - 1) << FRAC_W);
                    res.lookup_status = ST_ABOVE;
                    return res;
                end
                if (samples[mid + 1] > q) begin
                    res.mapped_value  = value_at(position_between(mid, samples[mid],
                                                                  samples[mid + 1], q));
                    res.lookup_status = ST_INTERP;
                    return res;
                end
                lo = mid + 1;
            end else if (samples[mid] > q) begin
                if (mid == 0) begin
                    res.mapped_value  = value_at('0);
                    res.lookup_status = ST_BELOW;
                    return res;
                end
                if (samples[mid - 1] < q) begin
                    res.mapped_value  = value_at(position_between(mid - 1, samples[mid - 1],
                                                                  samples[mid], q));
                    res.lookup_status = ST_INTERP;
                    return res;
                end
                hi = mid - 1;
            end else begin
                res.mapped_value  = value_at(64'(mid) << FRAC_W);
                res.lookup_status = ST_EXACT;
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_itp_out got;
        t_itp_out want;
        if (!i_rst_n) begin
            used_cnt  = ENTRIES_RESET;
            step_val  = STEP_RESET;
            first_val = FIRST_RESET;
            lookups_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_itp_cfg_idx'(i_cfg_idx))
                    CFG_ENTRIES_USED: used_cnt  = i_cfg_data[USED_W-1:0];
                    CFG_STEP_VALUE:   step_val  = i_cfg_data;
                    CFG_FIRST_VALUE:  first_val = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.opcode == OP_WRITE)
                    samples[i_in.entry_index] = i_in.sample_value;
                else
                    lookups_due.push_back(lookup(i_in.sample_value));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out;
                if (lookups_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MAX)
                        $display("unexpected result: mapped %0d status %0d",
                                 got.mapped_value, got.lookup_status);
                end else begin
                    want = lookups_due.pop_front();
                    if (got.mapped_value !== want.mapped_value ||
                        got.lookup_status !== want.lookup_status) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MAX)
                            $display("mismatch: mapped %0d status %0d, expected %0d status %0d",
                                     got.mapped_value, got.lookup_status,
                                     want.mapped_value, want.lookup_status);
                    end
                end
            end
        end
        o_pending    <= lookups_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/tb_inverse_table_interpolator.sv -----
// Testbench top of the inverse table interpolator: stimulus, back-pressure and verdict.
module tb_inverse_table_interpolator;
    import itp_pkg::*;

    localparam int HALF_PERIOD        = 2;
    localparam int RESET_CYCLES       = 9;
    localparam int DEPTH              = TABLE_DEPTH_DEF;
    localparam int USED_TOP           = 511;
    localparam int ITEM_TARGET        = 1000;
    // a write beat leaves no result behind, so give the block a full query time
    localparam int SETTLE_CYCLES      = 64;
    localparam int STALL_LIMIT        = 5000;
    localparam int HOLD_CYCLES        = 400;
    localparam int HOLD_AFTER_QUERIES = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_itp_in               i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_itp_out              o_out;

    int                    pending;
    int                    fail_count;
    int                    stall_cnt = 0;
    int                    beats_sent = 0;
    int                    queries_sent = 0;
    int                    burst_left = 0;

    // stimulus-side copy of the table, used only to aim lookups at it
    logic [SAMPLE_W-1:0]   shadow [DEPTH];

    always #HALF_PERIOD i_clk = ~i_clk;

    inverse_table_interpolator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    itp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Gap before the next beat: mostly none or short, now and then long, and
    // occasionally a burst of back-to-back beats.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Aim a lookup at the first n entries: exact hits, points between
    // neighbours, both field extremes, just outside either end and random values.
    function automatic logic [SAMPLE_W-1:0] pick_query(int n);
        int i;
        if (n == 0) return $urandom;
        i = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return shadow[i];
            1, 2, 3, 4: begin
                if (i + 1 < n && {1'b0, shadow[i + 1]} > {1'b0, shadow[i]} + 33'd1)
                    return shadow[i] + $urandom_range(1, shadow[i + 1] - shadow[i] - 1);
                return shadow[i];
            end
            5: return '0;
            6: return '1;
            7: return shadow[0] - 1;
            8: return shadow[n - 1] + 1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat and hold it until accepted. Valid drops only ahead of a
    // gap, so a back-to-back beat never sees valid lowered and raised in one step.
    task automatic send_beat(t_itp_op op, int idx, logic [SAMPLE_W-1:0] value);
        int      gap;
        t_itp_in beat;
        gap = pick_gap();
        beat.opcode       = op;
        beat.entry_index  = idx[ENTRY_IDX_W-1:0];
        beat.sample_value = value;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= beat;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        if (op == OP_WRITE)
            shadow[idx] = value;
        else
            queries_sent++;
    endtask

    // Drain every outstanding lookup, then let a possible trailing write finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_itp_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int used, logic [CFG_W-1:0] step, logic [CFG_W-1:0] first);
        cfg_write(CFG_ENTRIES_USED, CFG_W'(used));
        cfg_write(CFG_STEP_VALUE, step);
        cfg_write(CFG_FIRST_VALUE, first);
    endtask

    // Load entries 0..n-1, either strictly increasing (random start and
    // gaps, sometimes densely packed) or with arbitrary contents.
    task automatic fill_table(int n, bit ordered);
        longint room;
        longint span;
        longint v;
        room = (longint'(1) << 32) / (n + 1);
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                           : $urandom_range(1, 32'(room));
        v    = $urandom_range(0, 32'(span - 1));
        for (int i = 0; i < n; i++) begin
            send_beat(OP_WRITE, i, ordered ? 32'(v) : $urandom);
            v += $urandom_range(1, 32'(span));
        end
    endtask

    // Sender: directed beats first, then random phases, each with its own register
    // setting and lookups; phase 0 and partial counts also load a fresh table prefix.
    initial begin : stimulus
        int                used;
        int                n_eff;
        int                n_query;
        int                phase;
        int                r;
        logic [CFG_W-1:0]  step;
        logic [CFG_W-1:0]  first;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_ENTRIES_USED;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // four-entry table spanning the sample range; the top entry index
        // gets an all-ones write that no search reaches
        configure(4, 32'h0002_8000, 32'hFFFB_0000);
        send_beat(OP_WRITE, 0, 32'h0000_0010);
        send_beat(OP_WRITE, 1, 32'h1000_0000);
        send_beat(OP_WRITE, 2, 32'h8000_0000);
        send_beat(OP_WRITE, 3, 32'hFFFF_FFF0);
        send_beat(OP_WRITE, DEPTH - 1, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 0, 32'h0000_0000);
        send_beat(OP_QUERY, DEPTH - 1, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 0, 32'h1000_0000);
        send_beat(OP_QUERY, 0, 32'h4000_0000);
        send_beat(OP_QUERY, 0, 32'h0000_0011);
        send_beat(OP_QUERY, 0, 32'hFFFF_FFEF);
        send_beat(OP_QUERY, 0, 32'h8000_0000);

        // empty search range: nothing is searched, so the lookup misses
        settle();
        configure(0, STEP_RESET, FIRST_RESET);
        send_beat(OP_QUERY, 0, 32'h1234_5678);

        // single entry with the largest offset and step
        settle();
        configure(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_QUERY, 0, 32'h0000_0005);
        send_beat(OP_QUERY, 0, 32'h0000_0020);
        send_beat(OP_QUERY, 0, 32'h0000_0010);

        // most negative offset, zero step
        settle();
        configure(4, 32'h0000_0000, 32'h8000_0000);
        send_beat(OP_QUERY, 0, 32'h9000_0000);

        // break the ordering: a descending pair, then a duplicate
        settle();
        configure(4, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(OP_WRITE, 1, 32'hF000_0000);
        send_beat(OP_QUERY, 0, 32'h2000_0000);
        send_beat(OP_QUERY, 0, 32'hF800_0000);
        send_beat(OP_WRITE, 2, 32'hF000_0000);
        send_beat(OP_QUERY, 0, 32'hF000_0000);

        // Phase 0 loads the whole table so that later phases may search all of
        // it; phase 1 then tries a count beyond the table depth.
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            settle();
            r = $urandom_range(0, 99);
            if (phase == 0)
                used = DEPTH;
            else if (phase == 1)
                used = $urandom_range(DEPTH + 1, USED_TOP);
            else if (r < 4)
                used = 0;
            else if (r < 8)
                used = DEPTH;
            else if (r < 12)
                used = $urandom_range(DEPTH + 1, USED_TOP);
            else
                used = $urandom_range(1, 24);
            n_eff = (used > DEPTH) ? DEPTH : used;

            r = $urandom_range(0, 9);
            step = (r == 0) ? 32'h0000_0000 :
                   (r == 1) ? 32'hFFFF_FFFF :
                   (r < 5)  ? 32'($urandom_range(0, 32'h0004_0000)) : $urandom;
            r = $urandom_range(0, 9);
            first = (r == 0) ? 32'h7FFF_FFFF :
                    (r == 1) ? 32'h8000_0000 : $urandom;
            configure(used, step, first);

            if (phase == 0)
                fill_table(DEPTH, 1'b1);
            else if (n_eff > 0 && n_eff < DEPTH)
                fill_table(n_eff, $urandom_range(0, 4) != 0);

            // lookups with the odd rewrite mixed in; every entry is loaded by now
            n_query = $urandom_range(8, 40);
            repeat (n_query) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_WRITE, $urandom_range(0, DEPTH - 1), $urandom);
                else
                    send_beat(OP_QUERY, $urandom_range(0, DEPTH - 1), pick_query(n_eff));
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stretches of steady ready and random stalls, plus one long
    // hold while the sender keeps offering lookups, so the block backs up.
    initial begin : sink
        int  len;
        bit  held;
        held = 1'b0;
        forever begin
            if (!held && queries_sent >= HOLD_AFTER_QUERIES) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 2) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel and no register write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
